>>> rtl/psa_pkg.sv
// Shared types and constants of the persistence spectrum accumulator.
package psa_pkg;

   // Cell format: unsigned Q8.16
   localparam int CELL_W = 24;
   localparam logic [CELL_W-1:0] CELL_MAX = 24'hFF_FFFF;
   localparam logic [CELL_W-1:0] HIT_INC  = 24'd1311;

   // Shared multiplier operand and product widths
   localparam int MUL_A_W = 24;
   localparam int MUL_B_W = 17;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   // Decay factor 65470/65536
   localparam logic [MUL_B_W-1:0] DECAY_NUM = 17'd65470;

   // Register widths and reset values
   localparam int COLS_W = 11;
   localparam int ROWS_W = 9;
   localparam logic [COLS_W-1:0] COLS_RESET = 11'd1024;
   localparam logic [ROWS_W-1:0] ROWS_RESET = 9'd256;

   // Register index, taken from paddr bit 2
   localparam logic REG_COLUMN_COUNT = 1'b0;
   localparam logic REG_ROW_COUNT    = 1'b1;

   // Item kinds
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_READ   = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RD_FETCH,
      ST_RD_OUT,
      ST_DECAY,
      ST_ROW_MUL,
      ST_ROW_CHK,
      ST_HIT_ADD
   } psa_state_type;

endpackage

>>> rtl/persistence_spectrum_accumulator_unit.sv
// Top level of the persistence spectrum accumulator: density store, sequencer and CSRs.
//
// The block keeps a MAX_COLUMNS by MAX_ROWS store of unsigned Q8.16 densities in a
// single memory with one write and one registered read port. After reset the block
// clears the store, one cell per cycle, through all 2**(CW+RW) cells (262144 at the
// default sizes, CW and RW being the index widths of columns and rows); req_ready stays
// low meanwhile, while CSR writes are taken as usual. A read item passes through a
// fetch state and an output state, waiting in the latter for the result register to
// drain. A sample item that misses the store passes through row multiply and row check
// states, and one that adds to a cell also through a hit-add state: one pass through the
// shared multiplier to find the row, then a read-modify-write of the cell through the
// memory port. A sample with frame_start first sweeps every used cell through the same
// multiplier, one cell per cycle in a three-stage read / multiply / write pipeline.
// The block works on one item at a time; the result register lets a new item enter
// while a read result still waits to be taken.
module persistence_spectrum_accumulator_unit #(
   parameter int MAX_COLUMNS = 1024,
   parameter int MAX_ROWS    = 256
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [9:0]  req_column,
   input  logic [16:0] req_magnitude,
   input  logic        req_frame_start,
   input  logic [7:0]  req_read_row,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [23:0] rsp_cell_value,
   // CSR port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // Index widths: row in the upper address bits, column in the lower
   localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int AW = CW + RW;
   localparam int IX_W = 17;

   localparam int CELL_W = psa_pkg::CELL_W;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [psa_pkg::COLS_W-1:0] cols_ff, cols_in;
   logic [psa_pkg::ROWS_W-1:0] rows_ff, rows_in;
   logic                       csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cols_in = cols_ff;
      rows_in = rows_ff;
      if (csr_wr) begin
         unique case (csr_paddr[2])
            psa_pkg::REG_COLUMN_COUNT: cols_in = csr_pwdata[psa_pkg::COLS_W-1:0];
            psa_pkg::REG_ROW_COUNT:    rows_in = csr_pwdata[psa_pkg::ROWS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         psa_pkg::REG_COLUMN_COUNT: csr_prdata = 32'(cols_ff);
         psa_pkg::REG_ROW_COUNT:    csr_prdata = 32'(rows_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= psa_pkg::COLS_RESET;
         rows_ff <= psa_pkg::ROWS_RESET;
      end else begin
         cols_ff <= cols_in;
         rows_ff <= rows_in;
      end
   end

   // Clamp counts to the store size
   logic [psa_pkg::COLS_W-1:0] cols_eff;
   logic [psa_pkg::ROWS_W-1:0] rows_eff;

   always_comb begin
      cols_eff = (32'(cols_ff) > 32'(MAX_COLUMNS)) ? psa_pkg::COLS_W'(MAX_COLUMNS) : cols_ff;
      rows_eff = (32'(rows_ff) > 32'(MAX_ROWS)) ? psa_pkg::ROWS_W'(MAX_ROWS) : rows_ff;
   end

   // ------------------------------------------------------------------
   // State and datapath registers
   // ------------------------------------------------------------------
   psa_pkg::psa_state_type state_ff, state_in;

   logic [AW-1:0]  clr_addr_ff, clr_addr_in;

   // held item fields
   logic [9:0]     col_ff, col_in;
   logic [16:0]    mag_ff, mag_in;
   logic [7:0]     rrow_ff, rrow_in;

   // decay sweep position
   logic [psa_pkg::COLS_W-1:0] sw_col_ff, sw_col_in;
   logic [psa_pkg::ROWS_W-1:0] sw_row_ff, sw_row_in;
   logic                       sw_done_ff, sw_done_in;

   // decay pipeline: stage 1 holds read data, stage 2 holds the product
   logic           s1_vld_ff, s1_vld_in;
   logic [AW-1:0]  s1_addr_ff, s1_addr_in;
   logic           s2_vld_ff, s2_vld_in;
   logic [AW-1:0]  s2_addr_ff, s2_addr_in;

   logic [AW-1:0]  hit_addr_ff, hit_addr_in;

   logic           rsp_valid_ff, rsp_valid_in;
   logic [CELL_W-1:0] rsp_value_ff, rsp_value_in;

   // memory
   logic [CELL_W-1:0] mem [0:(1 << AW)-1];
   logic [CELL_W-1:0] rdata_ff;
   logic [AW-1:0]     rd_addr;
   logic              mem_we;
   logic [AW-1:0]     wr_addr;
   logic [CELL_W-1:0] mem_wdata;

   // shared multiplier
   logic [psa_pkg::MUL_A_W-1:0] mul_a;
   logic [psa_pkg::MUL_B_W-1:0] mul_b;
   logic [psa_pkg::PROD_W-1:0]  prod;

   psa_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   // ------------------------------------------------------------------
   // Index and decision logic
   // ------------------------------------------------------------------
   logic            req_acc;
   logic            out_free;
   logic [9:0]      row_sel;
   logic            hit;
   logic            rd_in_store;
   logic [IX_W-1:0] col_x, rrow_x, row_x, swc_x, swr_x;
   logic [AW-1:0]   sweep_addr, read_addr, hit_addr;
   logic [CELL_W:0] hit_sum;

   assign req_acc  = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      // row = floor(magnitude * rows); product stays below 2**26
      row_sel = prod[25:16];
      hit     = (32'(col_ff) < 32'(cols_eff)) && (row_sel != '0)
                && (row_sel < 10'(rows_eff));
      rd_in_store = (32'(col_ff) < 32'(MAX_COLUMNS)) && (32'(rrow_ff) < 32'(MAX_ROWS));

      col_x  = IX_W'(col_ff);
      rrow_x = IX_W'(rrow_ff);
      row_x  = IX_W'(row_sel);
      swc_x  = IX_W'(sw_col_ff);
      swr_x  = IX_W'(sw_row_ff);

      sweep_addr = {swr_x[RW-1:0], swc_x[CW-1:0]};
      read_addr  = {rrow_x[RW-1:0], col_x[CW-1:0]};
      hit_addr   = {row_x[RW-1:0], col_x[CW-1:0]};

      // saturate at the top of Q8.16
      hit_sum = {1'b0, rdata_ff} + {1'b0, psa_pkg::HIT_INC};
   end

   // ------------------------------------------------------------------
   // Sequencer: next state
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         psa_pkg::ST_CLEAR: begin
            if (&clr_addr_ff) state_in = psa_pkg::ST_IDLE;
         end
         psa_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_kind == psa_pkg::KIND_READ) state_in = psa_pkg::ST_RD_FETCH;
               else if (req_frame_start)           state_in = psa_pkg::ST_DECAY;
               else                                state_in = psa_pkg::ST_ROW_MUL;
            end
         end
         psa_pkg::ST_RD_FETCH: state_in = psa_pkg::ST_RD_OUT;
         psa_pkg::ST_RD_OUT: begin
            if (out_free) state_in = psa_pkg::ST_IDLE;
         end
         psa_pkg::ST_DECAY: begin
            if (sw_done_ff && !s1_vld_ff && !s2_vld_ff) state_in = psa_pkg::ST_ROW_MUL;
         end
         psa_pkg::ST_ROW_MUL: state_in = psa_pkg::ST_ROW_CHK;
         psa_pkg::ST_ROW_CHK: state_in = hit ? psa_pkg::ST_HIT_ADD : psa_pkg::ST_IDLE;
         psa_pkg::ST_HIT_ADD: state_in = psa_pkg::ST_IDLE;
         default:             state_in = psa_pkg::ST_IDLE;
      endcase
   end

   // ------------------------------------------------------------------
   // Sequencer: outputs to memory, multiplier and handshake
   // ------------------------------------------------------------------
   always_comb begin
      req_ready = 1'b0;
      mem_we    = 1'b0;
      wr_addr   = s2_addr_ff;
      mem_wdata = prod[CELL_W+15:16];
      rd_addr   = sweep_addr;
      mul_a     = rdata_ff;
      mul_b     = psa_pkg::DECAY_NUM;
      unique case (state_ff)
         psa_pkg::ST_CLEAR: begin
            mem_we    = 1'b1;
            wr_addr   = clr_addr_ff;
            mem_wdata = '0;
         end
         psa_pkg::ST_IDLE: begin
            req_ready = 1'b1;
         end
         psa_pkg::ST_RD_FETCH: begin
            rd_addr = read_addr;
         end
         psa_pkg::ST_RD_OUT: begin
            // hold the read address so the cell stays on rdata_ff while the result waits
            rd_addr = read_addr;
         end
         psa_pkg::ST_DECAY: begin
            // write back the truncated product of the cell two stages ahead
            mem_we = s2_vld_ff;
         end
         psa_pkg::ST_ROW_MUL: begin
            mul_a = psa_pkg::MUL_A_W'(mag_ff);
            mul_b = psa_pkg::MUL_B_W'(rows_eff);
         end
         psa_pkg::ST_ROW_CHK: begin
            rd_addr = hit_addr;
         end
         psa_pkg::ST_HIT_ADD: begin
            mem_we    = 1'b1;
            wr_addr   = hit_addr_ff;
            mem_wdata = hit_sum[CELL_W] ? psa_pkg::CELL_MAX : hit_sum[CELL_W-1:0];
         end
         default: ;
      endcase
   end

   // ------------------------------------------------------------------
   // Register next values
   // ------------------------------------------------------------------
   always_comb begin
      clr_addr_in  = clr_addr_ff;
      col_in       = col_ff;
      mag_in       = mag_ff;
      rrow_in      = rrow_ff;
      sw_col_in    = sw_col_ff;
      sw_row_in    = sw_row_ff;
      sw_done_in   = sw_done_ff;
      hit_addr_in  = hit_addr_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;

      if (state_ff == psa_pkg::ST_CLEAR) clr_addr_in = clr_addr_ff + AW'(1);

      // hold the item fields on accept; start the sweep at cell zero
      if (req_acc) begin
         col_in     = req_column;
         mag_in     = req_magnitude;
         rrow_in    = req_read_row;
         sw_col_in  = '0;
         sw_row_in  = '0;
         sw_done_in = (cols_eff == '0) || (rows_eff == '0);
      end

      // advance the sweep column first, then the row
      if (state_ff == psa_pkg::ST_DECAY && !sw_done_ff) begin
         if (sw_col_ff == cols_eff - psa_pkg::COLS_W'(1)) begin
            sw_col_in = '0;
            if (sw_row_ff == rows_eff - psa_pkg::ROWS_W'(1)) sw_done_in = 1'b1;
            else sw_row_in = sw_row_ff + psa_pkg::ROWS_W'(1);
         end else begin
            sw_col_in = sw_col_ff + psa_pkg::COLS_W'(1);
         end
      end

      if (state_ff == psa_pkg::ST_ROW_CHK) hit_addr_in = hit_addr;

      // drop the result on take; load a new one when the register is free
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (state_ff == psa_pkg::ST_RD_OUT && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = rd_in_store ? rdata_ff : '0;
      end
   end

   assign s1_vld_in  = (state_ff == psa_pkg::ST_DECAY) && !sw_done_ff;
   assign s1_addr_in = sweep_addr;
   assign s2_vld_in  = s1_vld_ff;
   assign s2_addr_in = s1_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= psa_pkg::ST_CLEAR;
         clr_addr_ff  <= '0;
         sw_done_ff   <= 1'b1;
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         sw_done_ff   <= sw_done_in;
         s1_vld_ff    <= s1_vld_in;
         s2_vld_ff    <= s2_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff       <= col_in;
      mag_ff       <= mag_in;
      rrow_ff      <= rrow_in;
      sw_col_ff    <= sw_col_in;
      sw_row_ff    <= sw_row_in;
      s1_addr_ff   <= s1_addr_in;
      s2_addr_ff   <= s2_addr_in;
      hit_addr_ff  <= hit_addr_in;
      rsp_value_ff <= rsp_value_in;
   end

   // ------------------------------------------------------------------
   // Density store
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (mem_we) mem[wr_addr] <= mem_wdata;
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[rd_addr];
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_value = rsp_value_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == psa_pkg::ST_IDLE) |-> !mem_we)
      else $error("store written while idle");

   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == psa_pkg::ST_RD_OUT))
      else $error("result raised outside read path");

   a_decay_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == psa_pkg::ST_DECAY && sw_done_ff && !s1_vld_ff && !s2_vld_ff)
      |=> (state_ff == psa_pkg::ST_ROW_MUL))
      else $error("decay sweep did not hand over to row selection");

   a_hit_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == psa_pkg::ST_HIT_ADD) |-> (mem_wdata >= rdata_ff))
      else $error("hit update lowered a cell");

endmodule

>>> rtl/psa_mul.sv
// Shared registered multiplier used for cell decay and row selection.
module psa_mul (
   input  logic                          clock,
   input  logic [psa_pkg::MUL_A_W-1:0]   op_a,
   input  logic [psa_pkg::MUL_B_W-1:0]   op_b,
   output logic [psa_pkg::PROD_W-1:0]    prod
);

   logic [psa_pkg::PROD_W-1:0] prod_ff;
   logic [psa_pkg::PROD_W-1:0] prod_in;

   always_comb begin
      prod_in = psa_pkg::PROD_W'(op_a) * psa_pkg::PROD_W'(op_b);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule
